FILE: rtl/assert_macros.svh
// Assertion macros shared by the DSA signer and verifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define DSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsv assertion failed");

// The antecedent implies the consequent in the next cycle.
`define DSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsv assertion failed");

// The condition never holds.
`define DSV_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("dsv assertion failed");

`endif

FILE: rtl/dsv_pkg.sv
// Package with the types, constants and codes of the DSA signer and verifier.
`default_nettype none
package dsv_pkg;

  localparam int WORD_BITS = 31;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_R_ZERO  = 2'd1,
    ST_K_NOINV = 2'd2,
    ST_S_NOINV = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_P = 2'd0,
    CFG_Q = 2'd1,
    CFG_G = 2'd2,
    CFG_X = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BASE, S_PW_INIT, S_PW_SQ, S_PW_MUL, S_PW_STEP, S_PW_RET,
    S_RMOD, S_CHK_R, S_IV_START, S_IV_RED, S_IV_LOOP, S_IV_DIV, S_IV_MUL,
    S_IV_RET, S_HM, S_XM, S_RX, S_HX, S_SS, S_U1, S_U2, S_PV, S_VMOD, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    R_Y, R_GK, R_A1, R_A2
  } pw_ret_t;

  typedef enum logic {
    I_K, I_S
  } iv_ret_t;

  typedef struct packed {
    word_t message_hash;
    word_t nonce;
  } request_t;

  typedef struct packed {
    word_t   public_key;
    word_t   sig_r;
    word_t   sig_s;
    word_t   check_value;
    logic    sig_valid;
    status_t status;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/dsv_modmul.sv
// Bit-serial modular multiplier, one bit of the multiplier per cycle.
`default_nettype none
module dsv_modmul import dsv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire word_t a,
  input  wire word_t b,
  input  wire word_t m,
  output logic       done,
  output word_t      res
);

  logic                 run;
  cnt_t                 cnt;
  word_t                acc;
  word_t                a_r;
  word_t                b_r;
  word_t                m_r;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   dbl_r;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   sum_r;

  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum   = dbl_r + (b_r[WORD_BITS-1] ? {1'b0, a_r} : '0);
    sum_r = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
      m_r <= m;
      cnt <= cnt_t'(WORD_BITS - 1);
    end else if (run) begin
      acc <= sum_r[WORD_BITS-1:0];
      b_r <= {b_r[WORD_BITS-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign res = (m_r == '0) ? '0 : acc;

endmodule
`default_nettype wire

FILE: rtl/dsv_div.sv
// Restoring divider, one quotient bit per cycle; a zero divisor gives remainder zero.
`default_nettype none
module dsv_div import dsv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire word_t a,
  input  wire word_t b,
  output logic       done,
  output word_t      quo,
  output word_t      rem
);

  logic               run;
  cnt_t               cnt;
  word_t              b_r;
  logic [WORD_BITS:0] part;
  logic [WORD_BITS:0] shift;
  logic               ge;

  always_comb begin
    shift = {part[WORD_BITS-1:0], quo[WORD_BITS-1]};
    ge    = shift >= {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= a;
      b_r  <= b;
      cnt  <= cnt_t'(WORD_BITS - 1);
    end else if (run) begin
      part <= ge ? shift - {1'b0, b_r} : shift;
      quo  <= {quo[WORD_BITS-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

  assign rem = (b_r == '0) ? '0 : part[WORD_BITS-1:0];

endmodule
`default_nettype wire

FILE: rtl/dsa_sign_verify.sv
// Top level of the DSA signer and verifier: sequencer, registers and shared units.
//
// One signature and its verification are paced by the shared bit-serial modular
// multiplier, which runs four 31-bit square-and-multiply exponentiations, and by
// the bit-serial divider used in the two extended Euclidean inversions. A beat is
// accepted when start is high and busy is low; the result is held on result for
// exactly the one cycle in which done is high, and the receiver cannot stall it.
// Configuration writes take effect at once and belong between beats.
`default_nettype none
`include "assert_macros.svh"
module dsa_sign_verify import dsv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output logic          done,
  output result_t       result,
  input  wire logic     cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire word_t    cfg_data
);

  state_t  state, state_next;
  logic    waiting, waiting_next;
  logic    use_mul, use_div, u_done;
  logic    mul_start, mul_done, div_start, div_done;
  word_t   mul_a, mul_b, mul_m, mul_res;
  word_t   div_a, div_b, div_quo, div_rem;

  word_t   cfg_p, cfg_q, cfg_g, cfg_x;
  word_t   h, k, base, y, r, s, v, kinv, w, hm, tmp, u2;
  word_t   pw_base, pw_exp, acc;
  cnt_t    cnt;
  word_t   r0, r1, t0, t1, qt, nr, iv_a, qm;
  logic    iv_ok;
  pw_ret_t pw_ret;
  iv_ret_t iv_ret;
  status_t stat;

  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    word_t gap;
    gap = m - b;
    return (a >= gap) ? a - gap : a + b;
  endfunction

  function automatic word_t sub_mod(word_t a, word_t b, word_t m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  dsv_modmul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mul_m),
    .done  (mul_done),
    .res   (mul_res)
  );

  dsv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign qm     = (qt == cfg_q) ? '0 : qt;
  assign u_done = mul_done | div_done;
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      waiting <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      waiting <= waiting_next;
      done    <= (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_p <= word_t'(2);
      cfg_q <= word_t'(2);
      cfg_g <= word_t'(1);
      cfg_x <= word_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_P: cfg_p <= cfg_data;
        CFG_Q: cfg_q <= cfg_data;
        CFG_G: cfg_g <= cfg_data;
        CFG_X: cfg_x <= cfg_data;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    use_mul    = 1'b0;
    use_div    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    mul_m      = '0;
    div_a      = '0;
    div_b      = '0;
    unique case (state)
      S_IDLE:     if (start) state_next = S_BASE;
      S_BASE: begin
        use_div = 1'b1; div_a = cfg_g; div_b = cfg_p;
        if (u_done) state_next = S_PW_INIT;
      end
      S_PW_INIT:  state_next = S_PW_SQ;
      S_PW_SQ: begin
        use_mul = 1'b1; mul_a = acc; mul_b = acc; mul_m = cfg_p;
        if (u_done) state_next = pw_exp[cnt] ? S_PW_MUL : S_PW_STEP;
      end
      S_PW_MUL: begin
        use_mul = 1'b1; mul_a = acc; mul_b = pw_base; mul_m = cfg_p;
        if (u_done) state_next = S_PW_STEP;
      end
      S_PW_STEP:  state_next = (cnt == '0) ? S_PW_RET : S_PW_SQ;
      S_PW_RET: begin
        unique case (pw_ret)
          R_Y:  state_next = S_PW_INIT;
          R_GK: state_next = S_RMOD;
          R_A1: state_next = S_PW_INIT;
          R_A2: state_next = S_PV;
        endcase
      end
      S_RMOD: begin
        use_div = 1'b1; div_a = tmp; div_b = cfg_q;
        if (u_done) state_next = S_CHK_R;
      end
      S_CHK_R:    state_next = (r == '0) ? S_FINISH : S_IV_START;
      S_IV_START: state_next = (cfg_q < word_t'(2)) ? S_IV_RET : S_IV_RED;
      S_IV_RED: begin
        use_div = 1'b1; div_a = iv_a; div_b = cfg_q;
        if (u_done) state_next = (div_rem == '0) ? S_IV_RET : S_IV_LOOP;
      end
      S_IV_LOOP:  state_next = (r1 == '0) ? S_IV_RET : S_IV_DIV;
      S_IV_DIV: begin
        use_div = 1'b1; div_a = r0; div_b = r1;
        if (u_done) state_next = S_IV_MUL;
      end
      S_IV_MUL: begin
        use_mul = 1'b1; mul_a = qm; mul_b = t1; mul_m = cfg_q;
        if (u_done) state_next = S_IV_LOOP;
      end
      S_IV_RET: begin
        unique case (iv_ret)
          I_K: state_next = iv_ok ? S_HM : S_FINISH;
          I_S: state_next = iv_ok ? S_U1 : S_FINISH;
        endcase
      end
      S_HM: begin
        use_div = 1'b1; div_a = h; div_b = cfg_q;
        if (u_done) state_next = S_XM;
      end
      S_XM: begin
        use_div = 1'b1; div_a = cfg_x; div_b = cfg_q;
        if (u_done) state_next = S_RX;
      end
      S_RX: begin
        use_mul = 1'b1; mul_a = r; mul_b = tmp; mul_m = cfg_q;
        if (u_done) state_next = S_HX;
      end
      S_HX:       state_next = S_SS;
      S_SS: begin
        use_mul = 1'b1; mul_a = kinv; mul_b = tmp; mul_m = cfg_q;
        if (u_done) state_next = S_IV_START;
      end
      S_U1: begin
        use_mul = 1'b1; mul_a = hm; mul_b = w; mul_m = cfg_q;
        if (u_done) state_next = S_U2;
      end
      S_U2: begin
        use_mul = 1'b1; mul_a = r; mul_b = w; mul_m = cfg_q;
        if (u_done) state_next = S_PW_INIT;
      end
      S_PV: begin
        use_mul = 1'b1; mul_a = tmp; mul_b = acc; mul_m = cfg_p;
        if (u_done) state_next = S_VMOD;
      end
      S_VMOD: begin
        use_div = 1'b1; div_a = tmp; div_b = cfg_q;
        if (u_done) state_next = S_FINISH;
      end
      S_FINISH:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
    mul_start    = use_mul && !waiting;
    div_start    = use_div && !waiting;
    waiting_next = (use_mul || use_div) ? (waiting ? !u_done : 1'b1) : 1'b0;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          h    <= request.message_hash;
          k    <= request.nonce;
          s    <= '0;
          v    <= '0;
          stat <= ST_OK;
        end
      end
      S_BASE: begin
        if (u_done) begin
          base    <= div_rem;
          pw_base <= div_rem;
          pw_exp  <= cfg_x;
          pw_ret  <= R_Y;
        end
      end
      S_PW_INIT: begin
        acc <= (cfg_p >= word_t'(2)) ? word_t'(1) : '0;
        cnt <= cnt_t'(WORD_BITS - 1);
      end
      S_PW_SQ, S_PW_MUL: begin
        if (u_done) acc <= mul_res;
      end
      S_PW_STEP: begin
        if (cnt != '0) cnt <= cnt - 1'b1;
      end
      S_PW_RET: begin
        case (pw_ret)
          R_Y: begin
            y      <= acc;
            pw_exp <= k;
            pw_ret <= R_GK;
          end
          R_GK: tmp <= acc;
          R_A1: begin
            tmp     <= acc;
            pw_base <= y;
            pw_exp  <= u2;
            pw_ret  <= R_A2;
          end
          default: ;
        endcase
      end
      S_RMOD: begin
        if (u_done) r <= div_rem;
      end
      S_CHK_R: begin
        if (r == '0) begin
          stat <= ST_R_ZERO;
        end else begin
          iv_a   <= k;
          iv_ret <= I_K;
        end
      end
      S_IV_START: begin
        if (cfg_q < word_t'(2)) iv_ok <= 1'b0;
      end
      S_IV_RED: begin
        if (u_done) begin
          iv_ok <= 1'b0;
          r0    <= cfg_q;
          r1    <= div_rem;
          t0    <= '0;
          t1    <= word_t'(1);
        end
      end
      S_IV_LOOP: begin
        if (r1 == '0) iv_ok <= (r0 == word_t'(1));
      end
      S_IV_DIV: begin
        if (u_done) begin
          qt <= div_quo;
          nr <= div_rem;
        end
      end
      S_IV_MUL: begin
        if (u_done) begin
          r0 <= r1;
          r1 <= nr;
          t0 <= t1;
          t1 <= sub_mod(t0, mul_res, cfg_q);
        end
      end
      S_IV_RET: begin
        case (iv_ret)
          I_K: begin
            if (iv_ok) kinv <= t0;
            else stat <= ST_K_NOINV;
          end
          default: begin
            if (iv_ok) w <= t0;
            else stat <= ST_S_NOINV;
          end
        endcase
      end
      S_HM: begin
        if (u_done) hm <= div_rem;
      end
      S_XM: begin
        if (u_done) tmp <= div_rem;
      end
      S_RX: begin
        if (u_done) tmp <= mul_res;
      end
      S_HX: tmp <= add_mod(hm, tmp, cfg_q);
      S_SS: begin
        if (u_done) begin
          s      <= mul_res;
          iv_a   <= mul_res;
          iv_ret <= I_S;
        end
      end
      S_U1: begin
        if (u_done) pw_exp <= mul_res;
      end
      S_U2: begin
        if (u_done) begin
          u2      <= mul_res;
          pw_base <= base;
          pw_ret  <= R_A1;
        end
      end
      S_PV: begin
        if (u_done) tmp <= mul_res;
      end
      S_VMOD: begin
        if (u_done) v <= div_rem;
      end
      S_FINISH: begin
        result.public_key  <= y;
        result.sig_r       <= r;
        result.sig_s       <= s;
        result.check_value <= v;
        result.sig_valid   <= (stat == ST_OK) && (v == r);
        result.status      <= stat;
      end
      default: ;
    endcase
  end

  `DSV_ASSERT_IMP(a_done_idle, done, !busy)
  `DSV_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `DSV_ASSERT_IMP(a_valid_ok, done && result.sig_valid, result.status == ST_OK)
  `DSV_ASSERT_NEVER(a_one_unit, mul_start && div_start)

endmodule
`default_nettype wire

FILE: verif/dsa_sign_verify_tb.sv
// Self-checking testbench for the DSA signer and verifier, with directed and random beats.
module dsa_sign_verify_tb;
  import dsv_pkg::*;

  localparam longint unsigned WMAX = 64'h7fff_ffff;
  localparam int STALL_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_P;
  word_t    cfg_data = '0;

  longint unsigned mod_p, mod_q, gen_g, key_x;
  result_t  pending_sigs[$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       sigs_checked = 0;
  int       idle_pct = 0;
  int       quiet_cycles = 0;

  dsa_sign_verify u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request), .busy(busy),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned reduce(longint unsigned a, longint unsigned m);
    return (m == 0) ? 0 : a % m;
  endfunction

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
    return (m == 0) ? 0 : ((a % m) * (b % m)) % m;
  endfunction

  function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
    longint unsigned acc;
    if (m == 0) return 0;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit invmod(longint unsigned a, longint unsigned m,
                                output longint unsigned inv);
    longint r0, r1, t0, t1, qt, tmp;
    inv = 0;
    if (m < 2) return 0;
    r0 = m;
    r1 = a % m;
    if (r1 == 0) return 0;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
      tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) return 0;
    inv = (t0 < 0) ? t0 + m : t0;
    return 1;
  endfunction

  function automatic result_t sign_and_verify(longint unsigned h, longint unsigned k);
    result_t res;
    longint unsigned y, r, s, v, kinv, w, u1, u2, hx;
    h = h & WMAX;
    k = k & WMAX;
    res = '0;
    s = 0;
    v = 0;
    y = powmod(gen_g, key_x, mod_p);
    r = reduce(powmod(gen_g, k, mod_p), mod_q);
    if (r == 0) begin
      res.status = ST_R_ZERO;
    end else if (!invmod(k, mod_q, kinv)) begin
      res.status = ST_K_NOINV;
    end else begin
      hx = (reduce(h, mod_q) + mulmod(r, key_x, mod_q)) % mod_q;
      s = mulmod(kinv, hx, mod_q);
      if (!invmod(s, mod_q, w)) begin
        res.status = ST_S_NOINV;
      end else begin
        res.status = ST_OK;
        u1 = mulmod(h, w, mod_q);
        u2 = mulmod(r, w, mod_q);
        v = reduce(mulmod(powmod(gen_g, u1, mod_p), powmod(y, u2, mod_p), mod_p), mod_q);
      end
    end
    res.public_key  = word_t'(y);
    res.sig_r       = word_t'(r);
    res.sig_s       = word_t'(s);
    res.check_value = word_t'(v);
    res.sig_valid   = (res.status == ST_OK) && (v == r);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $time);
  endtask

  always @(negedge clk) begin
    result_t exp;
    if (!rst && done) begin
      if (pending_sigs.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        exp = pending_sigs.pop_front();
        sigs_checked++;
        if (result.public_key != exp.public_key)
          report_mismatch("public_key", result.public_key, exp.public_key);
        if (result.sig_r != exp.sig_r) report_mismatch("sig_r", result.sig_r, exp.sig_r);
        if (result.sig_s != exp.sig_s) report_mismatch("sig_s", result.sig_s, exp.sig_s);
        if (result.check_value != exp.check_value)
          report_mismatch("check_value", result.check_value, exp.check_value);
        if (result.sig_valid != exp.sig_valid)
          report_mismatch("sig_valid", result.sig_valid, exp.sig_valid);
        if (result.status != exp.status) report_mismatch("status", result.status, exp.status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", pending_sigs.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(longint unsigned h, longint unsigned k);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= '{message_hash: word_t'(h), nonce: word_t'(k)};
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_sigs.push_back(sign_and_verify(h, k));
    beats_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_sigs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, longint unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word_t'(value);
    @(posedge clk);
    case (idx)
      CFG_P: mod_p = value;
      CFG_Q: mod_q = value;
      CFG_G: gen_g = value;
      default: key_x = value;
    endcase
  endtask

  task automatic load_config(longint unsigned p, longint unsigned q,
                             longint unsigned g, longint unsigned x);
    drain();
    write_reg(CFG_P, p);
    write_reg(CFG_Q, q);
    write_reg(CFG_G, g);
    write_reg(CFG_X, x);
    cfg_we <= 1'b0;
  endtask

  // A real subgroup of order 331 inside the multiplicative group mod 2^31-1.
  task automatic load_real_group();
    longint unsigned g;
    g = powmod(7, (WMAX - 1) / 331, WMAX);
    load_config(WMAX, 331, g, $urandom_range(330, 1));
  endtask

  task automatic test_reset_values();
    send_beat(0, 1);
    send_beat(WMAX, WMAX - 1);
    send_beat($urandom_range(32'h7fff_ffff), 2);
  endtask

  task automatic test_small_group_cases();
    longint unsigned r;
    load_config(23, 11, 4, 7);
    for (int k = 1; k <= 11; k++) send_beat($urandom_range(32'h7fff_ffff), k);
    r = reduce(powmod(4, 3, 23), 11);
    send_beat(11 - mulmod(r, 7, 11), 3);
    send_beat(0, 5);
    send_beat(WMAX, WMAX - 1);
  endtask

  task automatic test_extreme_config();
    load_config(WMAX, WMAX, WMAX - 1, WMAX - 1);
    send_beat(WMAX, WMAX - 1);
    send_beat(0, 1);
    load_config(2, 2, 1, 1);
    send_beat(WMAX, 1);
  endtask

  task automatic test_random_phase(int pct, int beats);
    idle_pct = pct;
    case ($urandom_range(2))
      0: load_real_group();
      1: load_config(23, 11, 4, $urandom_range(10, 1));
      default: load_config($urandom_range(32'h7fff_ffff, 2), $urandom_range(32'h7fff_ffff, 2),
                           $urandom_range(32'h7fff_ffff, 1), $urandom_range(32'h7fff_fffe, 1));
    endcase
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(3) == 0)
        send_beat($urandom_range(32'h7fff_ffff), $urandom_range(32'h7fff_fffe, 1));
      else
        send_beat($urandom_range(32'h7fff_ffff), $urandom_range(mod_q + 1, 1));
    end
  endtask

  initial begin
    mod_p = 2;
    mod_q = 2;
    gen_g = 1;
    key_x = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_small_group_cases();
    test_extreme_config();
    test_random_phase(0, 25);
    test_random_phase(50, 25);
    test_random_phase(26, 25);
    test_random_phase(0, 25);
    idle_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    $display("Signed and verified %0d beats over reset, small, real and extreme groups.",
             beats_sent);
    $display("Checked %0d results with %0d mismatches.", sigs_checked, mismatches);
    if (mismatches == 0 && pending_sigs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
